// ----- rtl/ffrag_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame fragmenter package
// Shared sizes, header layout positions and the queue entry type.
// ----------------------------------------------------------------------------
package ffrag_pkg;

   localparam int MAX_PACKET_BYTES = 1472;
   localparam int USER_WORDS       = 2;
   localparam int HDR_BYTES        = 18 + 4 * USER_WORDS;
   localparam int CHUNK_BYTES      = MAX_PACKET_BYTES - HDR_BYTES;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 24;
   localparam int TIME_W  = 64;
   localparam int SEQ_W   = 64;
   localparam int OFF_W   = 16;
   localparam int INDEX_W = 8;
   localparam int POS_W   = $clog2(HDR_BYTES);

   localparam int REQ_DATA_W = BYTE_W + LEN_W + TIME_W;
   localparam int RSP_DATA_W = BYTE_W;
   localparam int RSP_USER_W = 2;

   // Fragment count: length / chunk by reciprocal multiplication, then one correction.
   localparam int RECIP_SHIFT = LEN_W + 1;
   localparam int RECIP_W     = RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / CHUNK_BYTES);

   localparam logic [OFF_W-1:0] CHUNK_LIM     = OFF_W'(CHUNK_BYTES);
   localparam logic [LEN_W-1:0] CHUNK_LEN     = LEN_W'(CHUNK_BYTES);

   // Header byte positions.
   localparam logic [POS_W-1:0] POS_TIME  = POS_W'(8);
   localparam logic [POS_W-1:0] POS_INDEX = POS_W'(16);
   localparam logic [POS_W-1:0] POS_TOTAL = POS_W'(17);
   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(HDR_BYTES - 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [BYTE_W-1:0]  data_byte;
      logic [LEN_W-1:0]   length;
      logic [TIME_W-1:0]  timestamp;
      logic               frame_first;
      logic               frame_last;
      logic               hdr_before;
      logic               hdr_after;
      logic               pkt_end;
      logic [INDEX_W-1:0] index;
   } entry_type;

endpackage

// ----- rtl/ffrag_front.sv -----
// ----------------------------------------------------------------------------
// Frame fragmenter front end
// Accepts payload words, tracks frame and packet position, classifies each.
// ----------------------------------------------------------------------------
module ffrag_front import ffrag_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  q_full,
   output logic                  push,
   output entry_type             entry
);

   logic [LEN_W-1:0]   done_ff, done_in;
   logic [OFF_W-1:0]   offset_ff, offset_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [LEN_W-1:0]   length_ff, length_in;

   logic [LEN_W-1:0]   in_len, len_fix, lat_len, done1;
   logic [OFF_W-1:0]   off, off1;
   logic [INDEX_W-1:0] idx;
   logic               first, full, last;

   assign req_tready = !q_full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      in_len  = req_tdata[BYTE_W +: LEN_W];
      first   = (done_ff == '0);
      // A zero length is taken as one byte.
      len_fix = (in_len == '0) ? LEN_W'(1) : in_len;
      lat_len = first ? len_fix : length_ff;
      off     = first ? '0 : offset_ff;
      idx     = first ? '0 : index_ff;
      off1    = off + OFF_W'(1);
      done1   = done_ff + LEN_W'(1);
      full    = (off1 >= CHUNK_LIM);
      last    = (done1 == lat_len);

      entry.data_byte   = req_tdata[BYTE_W-1:0];
      entry.length      = lat_len;
      entry.timestamp   = req_tdata[BYTE_W + LEN_W +: TIME_W];
      entry.frame_first = first;
      entry.frame_last  = last;
      entry.hdr_before  = (off == '0);
      entry.hdr_after   = last && full;
      entry.pkt_end     = last || full;
      entry.index       = idx;

      length_in = lat_len;
      if (last) begin
         done_in   = '0;
         offset_in = '0;
         index_in  = '0;
      end else begin
         done_in   = done1;
         offset_in = full ? '0 : off1;
         index_in  = full ? idx + INDEX_W'(1) : idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff   <= '0;
         offset_ff <= '0;
         index_ff  <= '0;
         length_ff <= '0;
      end else if (push) begin
         done_ff   <= done_in;
         offset_ff <= offset_in;
         index_ff  <= index_in;
         length_ff <= length_in;
      end
   end

endmodule

// ----- rtl/ffrag_queue.sv -----
// ----------------------------------------------------------------------------
// Frame fragmenter queue
// Short first-in first-out store of classified words between front and back.
// ----------------------------------------------------------------------------
module ffrag_queue import ffrag_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type entry_in,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head,
   output logic      full
);

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/ffrag_back.sv -----
// ----------------------------------------------------------------------------
// Frame fragmenter back end
// Plays out headers and payload bytes for each queued word into the output.
// ----------------------------------------------------------------------------
module ffrag_back import ffrag_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  entry_type             head,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   typedef enum logic [1:0] {
      ST_ITEM,
      ST_PRE,
      ST_BODY,
      ST_TAIL
   } st_type;

   st_type             st_ff, st_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [SEQ_W-1:0]   seq_ff;
   logic [TIME_W-1:0]  time_ff;
   logic               rsp_valid_ff;
   logic [BYTE_W-1:0]  rsp_byte_ff, byte_in;
   logic               rsp_hdr_ff, rsp_end_ff, rsp_last_ff;

   // Fragment count pipeline.
   logic [LEN_W+RECIP_W-1:0] prod_ff;
   logic [LEN_W-1:0]         len1_ff;
   logic [LEN_W-1:0]         q2_ff, rem2_ff;
   logic [INDEX_W-1:0]       total_ff;
   logic [LEN_W-1:0]         q_est;

   logic               adv, go, start, is_hdr, is_payload, end_bit, last_bit, pop_c;
   logic [INDEX_W-1:0] hdr_index;

   assign adv   = !rsp_valid_ff || rsp_tready;
   assign go    = adv && head_valid;
   assign start = go && (st_ff == ST_ITEM) && head.frame_first;
   assign pop   = go && pop_c;

   always_comb begin
      st_in      = st_ff;
      pos_in     = pos_ff;
      is_hdr     = 1'b0;
      is_payload = 1'b0;
      end_bit    = 1'b0;
      last_bit   = 1'b0;
      pop_c      = 1'b0;
      hdr_index  = head.index;
      case (st_ff)
         ST_ITEM: begin
            if (head.hdr_before) begin
               is_hdr = 1'b1;
               pos_in = pos_ff + POS_W'(1);
               st_in  = ST_PRE;
            end else begin
               is_payload = 1'b1;
            end
         end
         ST_PRE: begin
            is_hdr = 1'b1;
            if (pos_ff == POS_LAST) begin
               pos_in = '0;
               st_in  = ST_BODY;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
         ST_BODY: begin
            is_payload = 1'b1;
         end
         ST_TAIL: begin
            is_hdr    = 1'b1;
            hdr_index = head.index + INDEX_W'(1);
            if (pos_ff == POS_LAST) begin
               end_bit  = 1'b1;
               last_bit = 1'b1;
               pop_c    = 1'b1;
               pos_in   = '0;
               st_in    = ST_ITEM;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
         default: begin
            st_in  = ST_ITEM;
            pos_in = '0;
         end
      endcase

      if (is_payload) begin
         end_bit = head.pkt_end;
         if (head.hdr_after) begin
            pos_in = '0;
            st_in  = ST_TAIL;
         end else begin
            last_bit = 1'b1;
            pop_c    = 1'b1;
            st_in    = ST_ITEM;
         end
      end

      // Header layout: sequence, time stamp, index, count, zero user words.
      if (!is_hdr) begin
         byte_in = head.data_byte;
      end else if (pos_ff < POS_TIME) begin
         byte_in = seq_ff[{pos_ff[2:0], 3'b000} +: BYTE_W];
      end else if (pos_ff < POS_INDEX) begin
         byte_in = time_ff[{pos_ff[2:0], 3'b000} +: BYTE_W];
      end else if (pos_ff == POS_INDEX) begin
         byte_in = hdr_index;
      end else if (pos_ff == POS_TOTAL) begin
         byte_in = total_ff;
      end else begin
         byte_in = '0;
      end
   end

   assign q_est = prod_ff[RECIP_SHIFT +: LEN_W];

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= head.length * RECIP;
         len1_ff <= head.length;
         time_ff <= head.timestamp;
      end
      q2_ff    <= q_est;
      rem2_ff  <= len1_ff - q_est * CHUNK_LEN;
      total_ff <= INDEX_W'(q2_ff + LEN_W'(1) + LEN_W'(rem2_ff >= CHUNK_LEN));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_ITEM;
         pos_ff       <= '0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go) begin
            st_ff  <= st_in;
            pos_ff <= pos_in;
         end
         if (pop && head.frame_last) begin
            seq_ff <= seq_ff + SEQ_W'(1);
         end
         if (adv) begin
            rsp_valid_ff <= head_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_byte_ff <= byte_in;
         rsp_hdr_ff  <= is_hdr;
         rsp_end_ff  <= end_bit;
         rsp_last_ff <= last_bit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = {rsp_end_ff, rsp_hdr_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/frame_fragmenter_unit.sv -----
// ----------------------------------------------------------------------------
// Frame fragmenter
// Cuts a byte stream of encoded frames into headed packets.
// ----------------------------------------------------------------------------
// The req channel takes one payload byte per word together with the frame
// length and time stamp; both are sampled on the first byte of each frame.
// The rsp channel gives one packet byte per word. Before every packet the
// block inserts a 26-byte header (sequence number, time stamp, fragment
// index, fragment count and zeroed user words, all little-endian). When a
// frame length is an exact multiple of the packet payload size, a
// header-only packet follows the last payload byte.
// tlast on rsp marks the last byte produced for one input word.
// An accepted word passes the queue and the output register on its way out.
// Throughput is one byte per cycle while rsp_tready is high. During each
// 26-byte header a two-entry queue absorbs input before req_tready drops.
// The fragment count comes from a three-stage multiply pipeline that
// finishes well before its header byte is due.
// Reset clears all frame state and the sequence number; no word is lost
// when rsp_tready is low, the output simply holds.
// ----------------------------------------------------------------------------
module frame_fragmenter_unit import ffrag_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // data_byte, frame_length, frame_timestamp
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_byte
   output logic [RSP_USER_W-1:0] rsp_tuser,   // is_header, packet_end
   output logic                  rsp_tlast
);

   entry_type front_entry, head;
   logic      push, pop, head_valid, q_full;

   // Front: tracks where each byte falls in its frame and packet.
   ffrag_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .entry      (front_entry)
   );

   // Queue: decouples input acceptance from header playback.
   ffrag_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .entry_in   (front_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .full       (q_full)
   );

   // Back: emits header and payload bytes into the output register.
   ffrag_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_pop_has_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

   a_tail_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && rsp_tuser[1] |-> rsp_tlast)
      else $error("closing header byte does not end its run");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame fragmenter testbench
// Streams frames of payload bytes into the fragmenter and checks every packet
// byte that comes out against a behavioural prediction of headers, payload
// and packet boundaries.
// ----------------------------------------------------------------------------
// Each accepted req word is passed to a ledger class, which predicts the
// packet bytes that the word must produce and queues them. Every rsp word is
// compared with the oldest queued byte, field by field.
// The run starts with a few hand-picked frames (extreme data bytes, extreme
// time stamps, a zero length), then random frames of mostly short lengths,
// and finally a frame with a huge length so that the fragment count wraps;
// that last frame is left open.
// Both sides idle at random, the receiver once holds off for a long stretch
// so that the block fills up, and the sender once waits for the block to
// drain completely.
// ----------------------------------------------------------------------------
module tb;
   import ffrag_pkg::*;

   localparam int RANDOM_ITEMS = 340;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 200;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [BYTE_W-1:0] out_byte;
      logic              is_header;
      logic              packet_end;
      logic              run_last;
   } pkt_byte_type;

   // Predicts the packet bytes for each payload byte and holds those still due.
   class packet_byte_ledger;
      bit [SEQ_W-1:0]   frame_seq;
      bit [LEN_W-1:0]   bytes_done;
      bit [OFF_W-1:0]   chunk_fill;
      bit [INDEX_W-1:0] frag_idx;
      bit [INDEX_W-1:0] frag_count;
      bit [LEN_W-1:0]   frame_len;
      bit [TIME_W-1:0]  frame_time;
      pkt_byte_type     awaited_bytes[$];
      int               errors;

      function new();
         frame_seq  = '0;
         bytes_done = '0;
         chunk_fill = '0;
         frag_idx   = '0;
         frag_count = '0;
         frame_len  = '0;
         frame_time = '0;
         errors     = 0;
      endfunction

      function int pending();
         return awaited_bytes.size();
      endfunction

      function void queue_header(bit closes);
         bit [BYTE_W-1:0] v;
         for (int p = 0; p < HDR_BYTES; p++) begin
            if (p < int'(POS_TIME))
               v = frame_seq[8*p +: 8];
            else if (p < int'(POS_INDEX))
               v = frame_time[8*(p-int'(POS_TIME)) +: 8];
            else if (p == int'(POS_INDEX))
               v = frag_idx;
            else if (p == int'(POS_TOTAL))
               v = frag_count;
            else
               v = '0;
            awaited_bytes.push_back('{v, 1'b1, closes && p == HDR_BYTES - 1, 1'b0});
         end
      endfunction

      function void note_payload(bit [BYTE_W-1:0] data, bit [LEN_W-1:0] len,
                                 bit [TIME_W-1:0] stamp);
         bit closes;
         pkt_byte_type tail;
         if (bytes_done == 0) begin
            frame_len  = (len == 0) ? LEN_W'(1) : len;
            frame_time = stamp;
            frag_count = INDEX_W'(int'(frame_len) / CHUNK_BYTES + 1);
            frag_idx   = '0;
            chunk_fill = '0;
         end
         if (chunk_fill == 0)
            queue_header(1'b0);
         chunk_fill = chunk_fill + 1'b1;
         bytes_done = bytes_done + 1'b1;
         closes = (chunk_fill >= CHUNK_LIM) || (bytes_done == frame_len);
         awaited_bytes.push_back('{data, 1'b0, closes, 1'b0});
         if (chunk_fill >= CHUNK_LIM) begin
            chunk_fill = '0;
            frag_idx   = frag_idx + 1'b1;
         end
         if (bytes_done == frame_len) begin
            // An exact multiple of the chunk size ends with a header-only packet.
            if (chunk_fill == 0)
               queue_header(1'b1);
            frame_seq  = frame_seq + 1'b1;
            bytes_done = '0;
            chunk_fill = '0;
            frag_idx   = '0;
         end
         tail = awaited_bytes.pop_back();
         tail.run_last = 1'b1;
         awaited_bytes.push_back(tail);
      endfunction

      function void check_packet_byte(logic [RSP_DATA_W-1:0] data,
                                      logic [RSP_USER_W-1:0] user, logic last);
         pkt_byte_type want;
         if (awaited_bytes.size() == 0) begin
            $error("unexpected word: out_byte %02h is_header %b packet_end %b run_last %b",
                   data, user[0], user[1], last);
            errors++;
            return;
         end
         want = awaited_bytes.pop_front();
         if (data !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, data);
            errors++;
         end
         if (user[0] !== want.is_header) begin
            $error("is_header: expected %b, actual %b", want.is_header, user[0]);
            errors++;
         end
         if (user[1] !== want.packet_end) begin
            $error("packet_end: expected %b, actual %b", want.packet_end, user[1]);
            errors++;
         end
         if (last !== want.run_last) begin
            $error("run_last: expected %b, actual %b", want.run_last, last);
            errors++;
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // data_byte, frame_length, frame_timestamp
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // out_byte
   logic [RSP_USER_W-1:0] rsp_tuser;        // is_header, packet_end
   logic                  rsp_tlast;

   packet_byte_ledger ledger;
   bit  sender_rush = 1'b0;
   int  quiet_cycles = 0;

   frame_fragmenter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Offers one payload word and returns at the edge where it is taken.
   // req_tvalid is left high so that a following word can go out back to back.
   task automatic send_word(input logic [BYTE_W-1:0] data, input logic [LEN_W-1:0] len,
                            input logic [TIME_W-1:0] stamp);
      int gap;
      gap = sender_rush ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {stamp, len, data};
      do @(posedge clock); while (!req_tready);
      ledger.note_payload(data, len, stamp);
   endtask

   // Only the first word of a frame carries a meaningful length and time stamp;
   // the others carry random values that the block must ignore.
   task automatic send_frame(input int len_field, input logic [TIME_W-1:0] stamp,
                             input int count);
      for (int i = 0; i < count; i++) begin
         if (i == 0)
            send_word(BYTE_W'($urandom), LEN_W'(len_field), stamp);
         else
            send_word(BYTE_W'($urandom), LEN_W'($urandom), {$urandom, $urandom});
      end
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   // Receiver: random back-pressure per word, with one long hold-off.
   initial begin : rsp_side
      int gap;
      int taken;
      bit held;
      bit rush;
      taken = 0;
      held  = 1'b0;
      rush  = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 64 == 0)
            rush = ($urandom_range(0, 2) == 0);
         gap = rush ? 0 : $urandom_range(0, 11);
         if (!held && taken == HOLD_AFTER) begin
            gap  = HOLD_CYCLES;
            held = 1'b1;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         ledger.check_packet_byte(rsp_tdata, rsp_tuser, rsp_tlast);
         taken++;
      end
   end

   // Watchdog: ends the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : req_side
      int sent;
      int len;
      int pick;
      logic [TIME_W-1:0] stamp;
      ledger    = new();
      sent      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Hand-picked frames: extreme bytes and time stamps, a zero length taken
      // as one, and frames whose later words carry all-ones, all-zero and other noise.
      send_word(8'h00, 24'd1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(8'hFF, 24'd0, 64'h8000_0000_0000_0000);
      send_word(8'hA5, 24'd3, 64'h7FFF_FFFF_FFFF_FFFF);
      send_word(8'h5A, 24'hFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(8'h80, 24'hFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(8'h01, 24'd2, 64'h0000_0000_0000_0000);
      send_word(8'h7F, 24'd0, 64'h0123_4567_89AB_CDEF);
      send_word(8'hFE, 24'd4, 64'hFEDC_BA98_7654_3210);
      send_word(8'h55, 24'd0, 64'h0);
      send_word(8'hAA, 24'd1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(8'h33, 24'hAB_CDEF, 64'h1);

      // Let the block empty out completely before the random part.
      wait_for_drain();

      while (sent < RANDOM_ITEMS) begin
         sender_rush = ($urandom_range(0, 3) == 0);
         pick  = $urandom_range(0, 9);
         stamp = (pick == 9) ? 64'h8000_0000_0000_0000 : {$urandom, $urandom};
         if (pick == 0)
            len = 0;
         else if (pick < 8)
            len = $urandom_range(1, 12);
         else
            len = $urandom_range(13, 80);
         send_frame(len, stamp, (len == 0) ? 1 : len);
         sent += (len == 0) ? 1 : len;
      end

      // A frame so long that its fragment count wraps; it is left unfinished.
      sender_rush = 1'b0;
      send_frame($urandom_range(24'h80_0000, 24'hFF_FFFF), {$urandom, $urandom}, 6);

      req_tvalid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.errors == 0 && ledger.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/ffrag_pkg.sv
rtl/ffrag_front.sv
rtl/ffrag_queue.sv
rtl/ffrag_back.sv
rtl/frame_fragmenter_unit.sv
tb/tb.sv
